[src/cacw_pkg.sv]
// Package for the crash alert cancel window controller.
// Holds the state encoding, register indexes, reset values and item structs.
// No dependencies; every module of the block imports it.
package cacw_pkg;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_STANDBY   = 3'b001,
        ST_PENDING   = 3'b010,
        ST_CONFIRMED = 3'b100
    } alert_state_t;

    // Encoding of the alert_state field of a result.
    localparam logic [1:0] CODE_STANDBY  = 2'd0;
    localparam logic [1:0] CODE_PENDING   = 2'd1;
    localparam logic [1:0] CODE_CONFIRMED = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CANCEL_WINDOW = 1'b0;
    localparam logic CFG_COOLDOWN      = 1'b1;

    localparam int CFG_WIDTH = 24;
    localparam logic [CFG_WIDTH-1:0] CANCEL_WINDOW_RESET = 24'd5000;
    localparam logic [CFG_WIDTH-1:0] COOLDOWN_RESET      = 24'd10000;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_pressed;
        logic        crash_trigger;
        logic [15:0] accel_magnitude;
    } sensor_item_t;

    typedef struct packed {
        logic        buzzer_on;
        logic        publish_valid;
        logic        publish_manual;
        logic [15:0] publish_magnitude;
        logic [1:0]  alert_state;
    } alert_item_t;

    // Maps a one-hot state to the result encoding.
    function automatic logic [1:0] state_code(alert_state_t st);
        logic [1:0] code;
        case (st)
            ST_STANDBY:   code = CODE_STANDBY;
            ST_PENDING:   code = CODE_PENDING;
            ST_CONFIRMED: code = CODE_CONFIRMED;
            default:      code = CODE_STANDBY;
        endcase
        return code;
    endfunction

endpackage

[src/cacw_in_if.sv]
// Valid/ready channel that carries one sensor step transaction.
// No dependencies.
interface cacw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        button_pressed;
    logic        crash_trigger;
    logic [15:0] accel_magnitude;

    modport source (output valid, output now_ms, output button_pressed,
                    output crash_trigger, output accel_magnitude, input ready);
    modport sink (input valid, input now_ms, input button_pressed,
                  input crash_trigger, input accel_magnitude, output ready);
endinterface

[src/cacw_out_if.sv]
// Valid/ready channel that carries one alert result transaction.
// No dependencies.
interface cacw_out_if;
    logic        valid;
    logic        ready;
    logic        buzzer_on;
    logic        publish_valid;
    logic        publish_manual;
    logic [15:0] publish_magnitude;
    logic [1:0]  alert_state;

    modport source (output valid, output buzzer_on, output publish_valid,
                    output publish_manual, output publish_magnitude,
                    output alert_state, input ready);
    modport sink (input valid, input buzzer_on, input publish_valid,
                  input publish_manual, input publish_magnitude,
                  input alert_state, output ready);
endinterface

[src/cacw_in_stage.sv]
// Input register of the alert controller.
// Depends on cacw_pkg and cacw_in_if.
module cacw_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    cacw_in_if.sink               sensor,
    input  logic                  advance,
    output logic                  item_valid,
    output cacw_pkg::sensor_item_t item
);
    import cacw_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    sensor_item_t item_reg;
    logic         accept;

    assign sensor.ready = !valid_reg || advance;
    assign accept       = sensor.valid && sensor.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.now_ms          <= sensor.now_ms;
            item_reg.button_pressed  <= sensor.button_pressed;
            item_reg.crash_trigger   <= sensor.crash_trigger;
            item_reg.accel_magnitude <= sensor.accel_magnitude;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/cacw_fsm.sv]
// Alert state machine, configuration registers and result decode.
// Depends on cacw_pkg.
module cacw_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [cacw_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                          step,
    input  cacw_pkg::sensor_item_t        item,
    output cacw_pkg::alert_item_t         result
);
    import cacw_pkg::*;

    logic [CFG_WIDTH-1:0] cancel_window_reg;
    logic [CFG_WIDTH-1:0] cooldown_reg;

    alert_state_t state_reg;
    alert_state_t state_next;
    logic         manual_reg;
    logic         manual_next;
    logic [31:0]  window_start_reg;
    logic [31:0]  window_start_next;
    logic [31:0]  last_exit_reg;
    logic [31:0]  last_exit_next;

    logic [31:0]  since_exit;
    logic [31:0]  elapsed;
    logic         cooldown_done;
    logic         window_done;
    logic         pub_valid;
    logic         pub_manual;
    logic [15:0]  pub_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cancel_window_reg <= CANCEL_WINDOW_RESET;
            cooldown_reg      <= COOLDOWN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CANCEL_WINDOW: cancel_window_reg <= cfg_data;
                CFG_COOLDOWN:      cooldown_reg      <= cfg_data;
                default:           cooldown_reg      <= cooldown_reg;
            endcase
        end
    end

    // Timestamp differences wrap modulo 2^32.
    assign since_exit    = item.now_ms - last_exit_reg;
    assign elapsed       = item.now_ms - window_start_reg;
    assign cooldown_done = since_exit >= {8'd0, cooldown_reg};
    assign window_done   = elapsed >= {8'd0, cancel_window_reg};

    always_comb
    begin
        state_next        = state_reg;
        manual_next       = manual_reg;
        window_start_next = window_start_reg;
        last_exit_next    = last_exit_reg;
        pub_valid         = 1'b0;
        pub_manual        = 1'b0;
        pub_mag           = 16'd0;
        case (state_reg)
            ST_STANDBY:
            begin
                if (item.crash_trigger && cooldown_done)
                begin
                    state_next        = ST_PENDING;
                    manual_next       = 1'b0;
                    window_start_next = item.now_ms;
                end
                else if (item.button_pressed)
                begin
                    state_next        = ST_PENDING;
                    manual_next       = 1'b1;
                    window_start_next = item.now_ms;
                end
            end
            ST_PENDING:
            begin
                if (item.button_pressed)
                begin
                    state_next     = ST_STANDBY;
                    manual_next    = 1'b0;
                    last_exit_next = item.now_ms;
                end
                else if (window_done)
                begin
                    state_next  = ST_CONFIRMED;
                    pub_valid   = 1'b1;
                    pub_manual  = manual_reg;
                    pub_mag     = item.accel_magnitude;
                    manual_next = 1'b0;
                end
            end
            ST_CONFIRMED:
            begin
                if (item.button_pressed)
                begin
                    state_next     = ST_STANDBY;
                    manual_next    = 1'b0;
                    last_exit_next = item.now_ms;
                end
            end
            default:
            begin
                state_next  = ST_STANDBY;
                manual_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_STANDBY;
            manual_reg       <= 1'b0;
            window_start_reg <= 32'd0;
            last_exit_reg    <= 32'd0;
        end
        else if (step)
        begin
            state_reg        <= state_next;
            manual_reg       <= manual_next;
            window_start_reg <= window_start_next;
            last_exit_reg    <= last_exit_next;
        end
    end

    assign result.buzzer_on         = state_next != ST_STANDBY;
    assign result.publish_valid     = pub_valid;
    assign result.publish_manual    = pub_manual;
    assign result.publish_magnitude = pub_mag;
    assign result.alert_state       = state_code(state_next);

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("alert state register is not one-hot");

    a_publish_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && pub_valid |-> state_reg == ST_PENDING)
        else $error("publish raised outside the pending state");

    a_quiet_standby_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg == ST_STANDBY && !item.button_pressed
            && !item.crash_trigger |=> state_reg == ST_STANDBY)
        else $error("standby left without a press or a trigger");

    a_exit_time_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg != ST_STANDBY && item.button_pressed
            |=> last_exit_reg == $past(item.now_ms) && !manual_reg)
        else $error("exit time not recorded on cancel or acknowledge");
`endif

endmodule

[src/cacw_out_stage.sv]
// Result register of the alert controller; drives the result channel.
// Depends on cacw_pkg and cacw_out_if.
module cacw_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cacw_pkg::alert_item_t d,
    output logic                 free,
    cacw_out_if.source           alert
);
    import cacw_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    alert_item_t data_reg;

    assign free = !valid_reg || alert.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (alert.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

    assign alert.valid             = valid_reg;
    assign alert.buzzer_on         = data_reg.buzzer_on;
    assign alert.publish_valid     = data_reg.publish_valid;
    assign alert.publish_manual    = data_reg.publish_manual;
    assign alert.publish_magnitude = data_reg.publish_magnitude;
    assign alert.alert_state       = data_reg.alert_state;

endmodule

[src/crash_alert_cancel_window_fsm_unit.sv]
// Top level of the crash alert controller with a cancel window.
// Depends on cacw_pkg, cacw_in_if, cacw_out_if, cacw_in_stage, cacw_fsm, cacw_out_stage.
//
//  Channel   Direction  Handshake          Contents
//  sensor    in         valid/ready        now_ms, button_pressed, crash_trigger, magnitude
//  alert     out        valid/ready        buzzer, publish fields, alert_state
//  cfg       in         cfg_write strobe   cfg_index, cfg_data (24 bit)
//
// One transaction is accepted per cycle while the result channel is not stalled,
// and each one yields exactly one result. A transaction passes the input register,
// then the state machine decision enters the result register with the state update.
// Reset is asynchronous and active low; it returns the controller to standby,
// clears the window start and exit time stamps and restores the register defaults.
// A stalled result channel holds the result register; the input register then
// keeps one more transaction before sensor.ready falls.
module crash_alert_cancel_window_fsm_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    cacw_in_if.sink                       sensor,
    cacw_out_if.source                    alert,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [cacw_pkg::CFG_WIDTH-1:0] cfg_data
);
    import cacw_pkg::*;

    logic         item_valid;
    sensor_item_t item;
    alert_item_t  result;
    logic         out_free;
    logic         advance;

    // A transaction moves from the input register into the result register,
    // and the controller state steps, whenever the result register has room.
    assign advance = item_valid && out_free;

    cacw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor     (sensor),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // The state machine looks at the registered transaction and decides the
    // next state and the result in one short combinational pass.
    cacw_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    cacw_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .d     (result),
        .free  (out_free),
        .alert (alert)
    );

endmodule
